>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ROC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ROC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ROC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ROC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/roc_pkg.sv
`timescale 1ns / 1ps

package roc_pkg;

  localparam int GRID_WIDTH  = 1024;
  localparam int GRID_HEIGHT = 512;
  localparam int COUNT_BITS  = 8;

  localparam int GRID_DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int XOFF_W     = $clog2(GRID_WIDTH);
  localparam int XLEN_W     = $clog2(GRID_WIDTH + 1);
  localparam int YOFF_W     = $clog2(GRID_HEIGHT);
  localparam int YLEN_W     = $clog2(GRID_HEIGHT + 1);

  localparam int OP_W       = 2;
  localparam int COORD_W    = 16;
  localparam int RECT_LEN_W = 12;
  localparam int CLIP_W_W   = 11;
  localparam int CLIP_H_W   = 10;
  localparam int COST_W     = 32;
  localparam int SPAN_W     = 18;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [CLIP_W_W-1:0]   CLIP_W_RST = 11'd1024;
  localparam logic [CLIP_H_W-1:0]   CLIP_H_RST = 10'd512;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_CLIP_X = 2'd0,
    REG_CLIP_Y = 2'd1,
    REG_CLIP_W = 2'd2,
    REG_CLIP_H = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP_X,
    ST_CLIP_Y,
    ST_ROW,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clip_x;
    logic signed [COORD_W-1:0] clip_y;
    logic [CLIP_W_W-1:0]       clip_width;
    logic [CLIP_H_W-1:0]       clip_height;
  } cfg_t;

  // One grid read in flight toward the update unit.
  typedef struct packed {
    logic              vld;
    logic              sub;
    logic [ADDR_W-1:0] addr;
  } cell_req_t;

  typedef struct packed {
    logic clr_cost;
    logic clr_sat;
  } acc_ctl_t;

endpackage

>>> rtl/roc_ifs.sv
`timescale 1ns / 1ps

interface roc_in_if;
  import roc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic [RECT_LEN_W-1:0]     rect_width;
  logic [RECT_LEN_W-1:0]     rect_height;

  modport source (output valid, op, rect_x, rect_y, rect_width, rect_height, input ready);
  modport sink   (input valid, op, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

interface roc_out_if;
  import roc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COST_W-1:0] total_cost;
  logic                     count_saturated;

  modport source (output valid, total_cost, count_saturated, input ready);
  modport sink   (input valid, total_cost, count_saturated, output ready);
endinterface

>>> rtl/rect_overlap_cost_grid_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Overlap cost grid: keeps a coverage count per cell of a clip window and a running cost.
// in_req carries one request (op, rect_x, rect_y, rect_width, rect_height) by valid/ready;
// out_res returns one result (total_cost, count_saturated) per request.
// Add/subtract requests step through ST_CLIP_X, ST_CLIP_Y, ST_ROW, ST_WALK (one step per
// cell of the nx*ny left after clipping), ST_DRAIN and ST_DONE; an empty clip goes from
// ST_CLIP_Y straight to ST_DONE. One grid RAM read-modify-write per cycle: reads issue
// every walk cycle, and each cell's write-back lands in the cycle after its read.
// A clear request sweeps the whole grid, one cell a cycle, GRID_WIDTH*GRID_HEIGHT cells
// (524288 at the default size). The unused op code reports the cost without a walk.
// One request is in work at a time; in_req.ready is high only while the sequencer idles.
// After reset the same sweep zeroes all 524288 cells of the grid with in_req.ready low;
// configuration writes over the APB port are taken at any time.
// The result sits in an output register, so a new request can be taken while out_res is
// stalled; a finished request then waits until the register frees up.
module rect_overlap_cost_grid_top (
  input  logic                            clk,
  input  logic                            rst_n,
  roc_in_if.sink                          in_req,
  roc_out_if.source                       out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [roc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [roc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [roc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import roc_pkg::*;

  cfg_t                     cfg;
  cell_req_t                cell_req;
  acc_ctl_t                 acc_ctl;
  logic                     out_free;
  logic                     result_load;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     clr_we;
  logic [ADDR_W-1:0]        clr_addr;
  logic                     acc_we;
  logic [ADDR_W-1:0]        acc_addr;
  logic [COUNT_BITS-1:0]    acc_data;
  logic [COUNT_BITS-1:0]    rd_data;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [COUNT_BITS-1:0]    ram_wdata;
  logic signed [COST_W-1:0] cost;
  logic                     sat;

  logic                     out_vld_r, out_vld_nxt;
  logic signed [COST_W-1:0] out_cost_r;
  logic                     out_sat_r;

  roc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  roc_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_req      (in_req),
    .out_free    (out_free),
    .result_load (result_load),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .clr_we      (clr_we),
    .clr_addr    (clr_addr),
    .cell_req    (cell_req),
    .acc_ctl     (acc_ctl)
  );

  roc_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cell_req (cell_req),
    .rd_data  (rd_data),
    .acc_ctl  (acc_ctl),
    .wr_en    (acc_we),
    .wr_addr  (acc_addr),
    .wr_data  (acc_data),
    .cost     (cost),
    .sat      (sat)
  );

  // The clear sweep and cell write-back never overlap; the sweep wins the port.
  assign ram_we    = clr_we | acc_we;
  assign ram_waddr = clr_we ? clr_addr : acc_addr;
  assign ram_wdata = clr_we ? '0 : acc_data;

  roc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (GRID_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Result register: load on completion, drop when the receiver takes it.
  assign out_free = !out_vld_r || out_res.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (result_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_cost_r <= cost;
      out_sat_r  <= sat;
    end
  end

  assign out_res.valid           = out_vld_r;
  assign out_res.total_cost      = out_cost_r;
  assign out_res.count_saturated = out_sat_r;

  `ROC_ASSERT(a_wr_excl, clk, rst_n, !(clr_we && acc_we), "sweep and write-back collide")
  `ROC_ASSERT_NEXT(a_one_req, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready, "request taken while busy")

endmodule

>>> rtl/roc_ram.sv
`timescale 1ns / 1ps

module roc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/roc_cfg.sv
`timescale 1ns / 1ps

module roc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [roc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [roc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [roc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output roc_pkg::cfg_t                   cfg
);
  import roc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_fire;

  assign pready  = 1'b1;
  assign idx     = reg_idx_t'(paddr[3:2]);
  assign wr_fire = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_fire) begin
      case (idx)
        REG_CLIP_X: cfg_nxt.clip_x      = pwdata[COORD_W-1:0];
        REG_CLIP_Y: cfg_nxt.clip_y      = pwdata[COORD_W-1:0];
        REG_CLIP_W: cfg_nxt.clip_width  = pwdata[CLIP_W_W-1:0];
        REG_CLIP_H: cfg_nxt.clip_height = pwdata[CLIP_H_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_x      <= '0;
      cfg_r.clip_y      <= '0;
      cfg_r.clip_width  <= CLIP_W_RST;
      cfg_r.clip_height <= CLIP_H_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CLIP_X: prdata = APB_DATA_W'(cfg_r.clip_x[COORD_W-1:0]);
      REG_CLIP_Y: prdata = APB_DATA_W'(cfg_r.clip_y[COORD_W-1:0]);
      REG_CLIP_W: prdata = APB_DATA_W'(cfg_r.clip_width);
      REG_CLIP_H: prdata = APB_DATA_W'(cfg_r.clip_height);
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/roc_walk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module roc_walk (
  input  logic                            clk,
  input  logic                            rst_n,
  input  roc_pkg::cfg_t                   cfg,
  roc_in_if.sink                          in_req,
  input  logic                            out_free,
  output logic                            result_load,
  output logic                            rd_en,
  output logic [roc_pkg::ADDR_W-1:0]      rd_addr,
  output logic                            clr_we,
  output logic [roc_pkg::ADDR_W-1:0]      clr_addr,
  output roc_pkg::cell_req_t              cell_req,
  output roc_pkg::acc_ctl_t               acc_ctl
);
  import roc_pkg::*;

  localparam logic [ADDR_W-1:0] GW_A     = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(GRID_DEPTH - 1);
  localparam logic [SPAN_W-1:0] GW_S     = SPAN_W'(GRID_WIDTH);
  localparam logic [SPAN_W-1:0] GH_S     = SPAN_W'(GRID_HEIGHT);

  state_t                    state_r, state_nxt;
  logic                      sub_r, sub_nxt;
  logic                      clr_item_r, clr_item_nxt;
  logic signed [COORD_W-1:0] rect_x_r, rect_x_nxt;
  logic signed [COORD_W-1:0] rect_y_r, rect_y_nxt;
  logic [RECT_LEN_W-1:0]     rect_w_r, rect_w_nxt;
  logic [RECT_LEN_W-1:0]     rect_h_r, rect_h_nxt;
  logic [XOFF_W-1:0]         ox_r, ox_nxt;
  logic [XLEN_W-1:0]         nx_r, nx_nxt;
  logic [YOFF_W-1:0]         oy_r, oy_nxt;
  logic [YLEN_W-1:0]         ny_r, ny_nxt;
  logic [XOFF_W-1:0]         x_r, x_nxt;
  logic [YOFF_W-1:0]         y_r, y_nxt;
  logic [ADDR_W-1:0]         row_base_r, row_base_nxt;
  logic [ADDR_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  cell_req_t                 req_r, req_nxt;

  // Shared span clipper, used once for x and once for y.
  logic signed [SPAN_W-1:0] lo, len, wlo, wlen, hi, whi, a, b;
  logic signed [SPAN_W-1:0] span_off, span_len;
  logic [SPAN_W-1:0]        ww_u, wh_u;
  logic                     x_last, y_last;

  assign ww_u = (SPAN_W'(cfg.clip_width) > GW_S) ? GW_S : SPAN_W'(cfg.clip_width);
  assign wh_u = (SPAN_W'(cfg.clip_height) > GH_S) ? GH_S : SPAN_W'(cfg.clip_height);

  always_comb begin
    if (state_r == ST_CLIP_Y) begin
      lo   = SPAN_W'(rect_y_r);
      len  = SPAN_W'(rect_h_r);
      wlo  = SPAN_W'(cfg.clip_y);
      wlen = wh_u;
    end else begin
      lo   = SPAN_W'(rect_x_r);
      len  = SPAN_W'(rect_w_r);
      wlo  = SPAN_W'(cfg.clip_x);
      wlen = ww_u;
    end
    a        = (lo > wlo) ? lo : wlo;
    hi       = lo + len;
    whi      = wlo + wlen;
    b        = (hi < whi) ? hi : whi;
    span_off = a - wlo;
    span_len = (b > a) ? (b - a) : '0;
  end

  assign x_last  = (XLEN_W'(x_r) + XLEN_W'(1)) == nx_r;
  assign y_last  = (YLEN_W'(y_r) + YLEN_W'(1)) == ny_r;
  assign rd_addr = row_base_r + ADDR_W'(ox_r) + ADDR_W'(x_r);

  always_comb begin
    state_nxt    = state_r;
    sub_nxt      = sub_r;
    clr_item_nxt = clr_item_r;
    rect_x_nxt   = rect_x_r;
    rect_y_nxt   = rect_y_r;
    rect_w_nxt   = rect_w_r;
    rect_h_nxt   = rect_h_r;
    ox_nxt       = ox_r;
    nx_nxt       = nx_r;
    oy_nxt       = oy_r;
    ny_nxt       = ny_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    row_base_nxt = row_base_r;
    clr_cnt_nxt  = clr_cnt_r;
    req_nxt      = '0;
    in_req.ready = 1'b0;
    result_load  = 1'b0;
    rd_en        = 1'b0;
    clr_we       = 1'b0;
    clr_addr     = clr_cnt_r;
    acc_ctl      = '0;

    case (state_r)
      ST_CLEAR: begin
        clr_we           = 1'b1;
        acc_ctl.clr_cost = 1'b1;
        if (clr_cnt_r == LAST_A) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? ST_DONE : ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          acc_ctl.clr_sat = 1'b1;
          rect_x_nxt      = in_req.rect_x;
          rect_y_nxt      = in_req.rect_y;
          rect_w_nxt      = in_req.rect_width;
          rect_h_nxt      = in_req.rect_height;
          sub_nxt         = (in_req.op == OP_SUB);
          case (in_req.op)
            OP_ADD, OP_SUB: state_nxt = ST_CLIP_X;
            OP_CLEAR: begin
              clr_item_nxt = 1'b1;
              clr_cnt_nxt  = '0;
              state_nxt    = ST_CLEAR;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLIP_X: begin
        ox_nxt    = span_off[XOFF_W-1:0];
        nx_nxt    = span_len[XLEN_W-1:0];
        state_nxt = ST_CLIP_Y;
      end
      ST_CLIP_Y: begin
        oy_nxt = span_off[YOFF_W-1:0];
        ny_nxt = span_len[YLEN_W-1:0];
        // Empty clip on either axis: nothing to walk.
        if ((nx_r == '0) || (span_len == '0)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        row_base_nxt = ADDR_W'(oy_r) * GW_A;
        x_nxt        = '0;
        y_nxt        = '0;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        rd_en        = 1'b1;
        req_nxt.vld  = 1'b1;
        req_nxt.sub  = sub_r;
        req_nxt.addr = rd_addr;
        if (x_last) begin
          x_nxt = '0;
          if (y_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            y_nxt        = y_r + YOFF_W'(1);
            row_base_nxt = row_base_r + GW_A;
          end
        end else begin
          x_nxt = x_r + XOFF_W'(1);
        end
      end
      ST_DRAIN: begin
        // Let the last write-back land before reporting.
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          result_load = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_item_r <= 1'b0;
      clr_cnt_r  <= '0;
      req_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_item_r <= clr_item_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      req_r      <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r      <= sub_nxt;
    rect_x_r   <= rect_x_nxt;
    rect_y_r   <= rect_y_nxt;
    rect_w_r   <= rect_w_nxt;
    rect_h_r   <= rect_h_nxt;
    ox_r       <= ox_nxt;
    nx_r       <= nx_nxt;
    oy_r       <= oy_nxt;
    ny_r       <= ny_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    row_base_r <= row_base_nxt;
  end

  assign cell_req = req_r;

  `ROC_ASSERT(a_rd_in_grid, clk, rst_n, !rd_en || (rd_addr <= LAST_A), "grid read beyond depth")
  `ROC_ASSERT(a_x_in_span, clk, rst_n, (state_r != ST_WALK) || (XLEN_W'(x_r) < nx_r), "column past clipped span")

endmodule

>>> rtl/roc_acc.sv
`timescale 1ns / 1ps

module roc_acc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  roc_pkg::cell_req_t                cell_req,
  input  logic [roc_pkg::COUNT_BITS-1:0]    rd_data,
  input  roc_pkg::acc_ctl_t                 acc_ctl,
  output logic                              wr_en,
  output logic [roc_pkg::ADDR_W-1:0]        wr_addr,
  output logic [roc_pkg::COUNT_BITS-1:0]    wr_data,
  output logic signed [roc_pkg::COST_W-1:0] cost,
  output logic                              sat
);
  import roc_pkg::*;

  localparam int DELTA_W = COUNT_BITS + 2;
  localparam int SUM_W   = COST_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'd1 << (COST_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

  logic signed [COST_W-1:0]  cost_r, cost_nxt;
  logic                      sat_r, sat_nxt;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum;
  logic                      upd;
  logic                      hit;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    delta   = '0;
    upd     = 1'b0;
    hit     = 1'b0;
    if (cell_req.vld) begin
      if (!cell_req.sub) begin
        if (rd_data == COUNT_MAX) begin
          hit = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data + COUNT_BITS'(1);
          upd     = (rd_data != '0);
          delta   = DELTA_W'(rd_data) + DELTA_W'(1);
        end
      end else begin
        if (rd_data == '0) begin
          hit = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data - COUNT_BITS'(1);
          upd     = (rd_data != COUNT_BITS'(1));
          delta   = -DELTA_W'(rd_data);
        end
      end
    end
  end

  assign wr_addr = cell_req.addr;
  assign sum     = SUM_W'(cost_r) + SUM_W'(delta);

  always_comb begin
    cost_nxt = cost_r;
    if (acc_ctl.clr_cost) begin
      cost_nxt = '0;
    end else if (upd) begin
      if (sum > SUM_MAX) begin
        cost_nxt = SUM_MAX[COST_W-1:0];
      end else if (sum < SUM_MIN) begin
        cost_nxt = SUM_MIN[COST_W-1:0];
      end else begin
        cost_nxt = sum[COST_W-1:0];
      end
    end
    sat_nxt = acc_ctl.clr_sat ? 1'b0 : (sat_r | hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      cost_r <= cost_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign cost = cost_r;
  assign sat  = sat_r;

endmodule
